// ===== rtl/tps_pkg.sv =====
// Package for the tick process scheduler: policy codes, state machine states,
// reset constants and the command/status structs between controller and datapath.
// No dependencies.
package tps_pkg;

  // Default sizes and fixed field widths.
  localparam int MaxJobsDef   = 64;
  localparam int TimeBitsDef  = 24;
  localparam int BURST_W      = 24;
  localparam int SLOT_OUT_W   = 6;
  localparam int QUANTUM_W    = 16;
  localparam int JOB_TOTAL_W  = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_DATA_W   = 16;

  localparam logic [QUANTUM_W-1:0]   QUANTUM_RST   = QUANTUM_W'(500);
  localparam logic [JOB_TOTAL_W-1:0] JOB_TOTAL_RST = JOB_TOTAL_W'(1);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_JOB_TOTAL = 2'd2;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RET,
    S_DECIDE,
    S_POP,
    S_SCAN,
    S_APPLY,
    S_DEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic arrive;      // store an arriving job
    logic rd_cur;      // read the running job's remaining time, clear flags
    logic retire;      // retire the running job if its time is used up
    logic cand_cur;    // candidate is the running job
    logic cand_fifo;   // candidate is the next slot in arrival order
    logic pop;         // read the ring head
    logic pop_push;    // the running job goes to the ring tail after the pop
    logic pop_take;    // candidate is the popped slot
    logic scan_start;  // clear the shortest-job search
    logic scan_run;    // one step of the shortest-job search
    logic cand_best;   // candidate is the search winner
    logic apply;       // switch to the candidate, read its remaining time
    logic decrement;   // run the current job for one tick
    logic load_out;    // move the tick result to the output register
  } tps_cmd_t;

  typedef struct packed {
    policy_t policy;
    logic    cur_valid;
    logic    fifo_avail;
    logic    ring_empty;
    logic    slice_zero;
    logic    done;
    logic    scan_busy;
    logic    best_valid;
    logic    out_free;
  } tps_status_t;

endpackage

// ===== rtl/tps_ctrl.sv =====
// Controller state machine of the tick process scheduler.
// Depends on tps_pkg; drives commands into tps_dp and reads its status.
module tps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_mode,
  input  tps_pkg::tps_status_t  status,
  output tps_pkg::tps_cmd_t     cmd
);
  import tps_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_RET;
      S_RET: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (status.done) begin
          state_nxt = S_OUT;
        end else begin
          unique case (status.policy)
            POL_FIFO: begin
              if (status.cur_valid || status.fifo_avail) begin
                state_nxt = S_APPLY;
              end else begin
                state_nxt = S_OUT;
              end
            end
            POL_RR: begin
              if (status.ring_empty) begin
                state_nxt = status.cur_valid ? S_APPLY : S_OUT;
              end else if (!status.cur_valid || status.slice_zero) begin
                state_nxt = S_POP;
              end else begin
                state_nxt = S_APPLY;
              end
            end
            POL_SJF: begin
              state_nxt = status.cur_valid ? S_APPLY : S_SCAN;
            end
            POL_PSJF: state_nxt = S_SCAN;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_POP: state_nxt = S_APPLY;
      S_SCAN: begin
        if (!status.scan_busy) begin
          state_nxt = status.best_valid ? S_APPLY : S_OUT;
        end
      end
      S_APPLY: state_nxt = S_DEC;
      S_DEC:   state_nxt = S_OUT;
      S_OUT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.arrive = accept & ~in_mode;
      S_RD:   cmd.rd_cur = 1'b1;
      S_RET:  cmd.retire = 1'b1;
      S_DECIDE: begin
        if (!status.done) begin
          unique case (status.policy)
            POL_FIFO: begin
              if (status.cur_valid) begin
                cmd.cand_cur = 1'b1;
              end else begin
                cmd.cand_fifo = status.fifo_avail;
              end
            end
            POL_RR: begin
              if (status.ring_empty) begin
                cmd.cand_cur = status.cur_valid;
              end else if (!status.cur_valid) begin
                cmd.pop = 1'b1;
              end else if (status.slice_zero) begin
                cmd.pop      = 1'b1;
                cmd.pop_push = 1'b1;
              end else begin
                cmd.cand_cur = 1'b1;
              end
            end
            POL_SJF: begin
              if (status.cur_valid) begin
                cmd.cand_cur = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
              end
            end
            POL_PSJF: cmd.scan_start = 1'b1;
            default:  cmd = '0;
          endcase
        end
      end
      S_POP: cmd.pop_take = 1'b1;
      S_SCAN: begin
        cmd.scan_run  = status.scan_busy;
        cmd.cand_best = ~status.scan_busy & status.best_valid;
      end
      S_APPLY: cmd.apply     = 1'b1;
      S_DEC:   cmd.decrement = 1'b1;
      S_OUT:   cmd.load_out  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/tps_dp.sv =====
// Datapath of the tick process scheduler: configuration registers, the
// remaining-time and ready-ring memories, search logic and the output register.
// Depends on tps_pkg; driven by commands from tps_ctrl.
module tps_dp #(
  parameter int MAX_JOBS  = tps_pkg::MaxJobsDef,
  parameter int TIME_BITS = tps_pkg::TimeBitsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tps_pkg::tps_cmd_t                   cmd,
  output tps_pkg::tps_status_t                status,
  input  logic                                cfg_valid,
  input  logic [tps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tps_pkg::BURST_W-1:0]         in_burst,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tps_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import tps_pkg::*;

  localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_JOBS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_JOBS - 1);
  localparam logic [JOB_TOTAL_W-1:0] FIN_SAT = '1;

  // Configuration.
  policy_t                policy_r;
  logic [QUANTUM_W-1:0]   quantum_r;
  logic [JOB_TOTAL_W-1:0] job_total_r;

  // Memories.
  logic [TIME_BITS-1:0] rem_mem [MAX_JOBS];
  logic [SLOT_W-1:0]    ring_mem [MAX_JOBS];
  logic [TIME_BITS-1:0] rem_rd_r;
  logic [SLOT_W-1:0]    ring_rd_r;

  // Scheduler state.
  logic [CNT_W-1:0]       arrived_r;
  logic [JOB_TOTAL_W-1:0] finished_r;
  logic                   cur_v_r;
  logic [SLOT_W-1:0]      cur_slot_r;
  logic [CNT_W-1:0]       fifo_ptr_r;
  logic [SLOT_W-1:0]      head_r;
  logic [SLOT_W-1:0]      tail_r;
  logic [CNT_W-1:0]       ring_cnt_r;
  logic [QUANTUM_W-1:0]   slice_r;
  logic [SLOT_W-1:0]      cand_r;
  logic                   push_pend_r;

  // Search state.
  logic [CNT_W-1:0]     scan_idx_r;
  logic                 pipe_v_r;
  logic [SLOT_W-1:0]    pipe_idx_r;
  logic                 best_v_r;
  logic [SLOT_W-1:0]    best_idx_r;
  logic [TIME_BITS-1:0] best_rem_r;

  // Tick result.
  logic              run_v_r;
  logic              fin_v_r;
  logic [SLOT_W-1:0] fin_s_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 arrive_ok;
  logic                 push_en;
  logic [SLOT_W-1:0]    push_slot;
  logic [SLOT_W-1:0]    rem_rd_addr;
  logic                 rem_we;
  logic [SLOT_W-1:0]    rem_wr_addr;
  logic [TIME_BITS-1:0] rem_wr_data;
  logic                 scan_issue;
  logic                 better;
  logic                 done;
  logic                 out_free;
  logic                 switch_job;
  logic [QUANTUM_W:0]   slice_sum;

  assign arrive_ok = cmd.arrive && (arrived_r < CNT_MAX);
  assign push_en   = (arrive_ok && (policy_r == POL_RR) && (ring_cnt_r < CNT_MAX)) ||
                     (cmd.pop_take && push_pend_r);
  assign push_slot = cmd.pop_take ? cur_slot_r : arrived_r[SLOT_W-1:0];
  assign scan_issue = cmd.scan_run && (scan_idx_r < arrived_r);
  assign done      = (finished_r >= job_total_r);
  assign out_free  = ~out_valid_r | out_tready;
  assign switch_job = ~cur_v_r || (cand_r != cur_slot_r);
  assign slice_sum = {1'b0, slice_r} + 1'b1;
  assign better    = (rem_rd_r != '0) && (!best_v_r || (rem_rd_r < best_rem_r));

  always_comb begin
    if (cmd.scan_run) begin
      rem_rd_addr = scan_idx_r[SLOT_W-1:0];
    end else if (cmd.apply) begin
      rem_rd_addr = cand_r;
    end else begin
      rem_rd_addr = cur_slot_r;
    end
  end

  always_comb begin
    rem_we      = arrive_ok | cmd.decrement;
    rem_wr_addr = cmd.decrement ? cur_slot_r : arrived_r[SLOT_W-1:0];
    if (cmd.decrement) begin
      rem_wr_data = (rem_rd_r != '0) ? rem_rd_r - 1'b1 : '0;
    end else begin
      rem_wr_data = TIME_BITS'(in_burst);
    end
  end

  // Remaining-time memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wr_addr] <= rem_wr_data;
    end
    rem_rd_r <= rem_mem[rem_rd_addr];
  end

  // Ready ring memory.
  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_mem[tail_r] <= push_slot;
    end
    ring_rd_r <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIFO;
      quantum_r   <= QUANTUM_RST;
      job_total_r <= JOB_TOTAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLICY:    policy_r    <= policy_t'(cfg_data[1:0]);
        CFG_QUANTUM:   quantum_r   <= cfg_data;
        CFG_JOB_TOTAL: job_total_r <= cfg_data[JOB_TOTAL_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrived_r   <= '0;
      finished_r  <= '0;
      cur_v_r     <= 1'b0;
      fifo_ptr_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      ring_cnt_r  <= '0;
      slice_r     <= '0;
      push_pend_r <= 1'b0;
      scan_idx_r  <= '0;
      pipe_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      run_v_r     <= 1'b0;
      fin_v_r     <= 1'b0;
    end else begin
      if (arrive_ok) begin
        arrived_r <= arrived_r + 1'b1;
      end

      // The ring never pops and pushes in the same cycle.
      if (push_en) begin
        tail_r     <= (tail_r == SLOT_LAST) ? '0 : tail_r + 1'b1;
        ring_cnt_r <= ring_cnt_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r      <= (head_r == SLOT_LAST) ? '0 : head_r + 1'b1;
        ring_cnt_r  <= ring_cnt_r - 1'b1;
        push_pend_r <= cmd.pop_push;
      end

      if (cmd.rd_cur) begin
        run_v_r <= 1'b0;
        fin_v_r <= 1'b0;
      end
      if (cmd.retire && cur_v_r && (rem_rd_r == '0)) begin
        fin_v_r <= 1'b1;
        cur_v_r <= 1'b0;
        if (finished_r != FIN_SAT) begin
          finished_r <= finished_r + 1'b1;
        end
      end

      if (cmd.cand_fifo) begin
        fifo_ptr_r <= fifo_ptr_r + 1'b1;
      end

      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        best_v_r   <= 1'b0;
      end else if (scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      pipe_v_r <= scan_issue;
      if (pipe_v_r && better) begin
        best_v_r <= 1'b1;
      end

      if (cmd.apply && switch_job) begin
        cur_v_r <= 1'b1;
        slice_r <= '0;
      end
      if (cmd.decrement) begin
        run_v_r <= 1'b1;
        // The slice wraps when it reaches the quantum; a zero quantum acts as one.
        slice_r <= (slice_sum >= {1'b0, quantum_r}) ? '0 : slice_sum[QUANTUM_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      fin_s_r <= cur_slot_r;
    end
    if (cmd.cand_cur) begin
      cand_r <= cur_slot_r;
    end else if (cmd.cand_fifo) begin
      cand_r <= fifo_ptr_r[SLOT_W-1:0];
    end else if (cmd.pop_take) begin
      cand_r <= ring_rd_r;
    end else if (cmd.cand_best) begin
      cand_r <= best_idx_r;
    end
    if (cmd.apply) begin
      cur_slot_r <= cand_r;
    end
    pipe_idx_r <= scan_idx_r[SLOT_W-1:0];
    if (pipe_v_r && better) begin
      best_idx_r <= pipe_idx_r;
      best_rem_r <= rem_rd_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {1'b0,
                     done,
                     fin_v_r ? SLOT_OUT_W'(fin_s_r) : '0,
                     fin_v_r,
                     run_v_r ? SLOT_OUT_W'(cur_slot_r) : '0,
                     run_v_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    status            = '0;
    status.policy     = policy_r;
    status.cur_valid  = cur_v_r;
    status.fifo_avail = (fifo_ptr_r < arrived_r);
    status.ring_empty = (ring_cnt_r == '0);
    status.slice_zero = (slice_r == '0);
    status.done       = done;
    status.scan_busy  = (scan_idx_r < arrived_r) || pipe_v_r;
    status.best_valid = best_v_r;
    status.out_free   = out_free;
  end

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_cnt_r <= CNT_MAX)
    else $error("ring occupancy exceeds the job capacity");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ptr_r <= arrived_r)
    else $error("arrival-order pointer passed the arrived jobs");

  a_cur_arrived: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> ({1'b0, cur_slot_r} < {1'b0, arrived_r}))
    else $error("running slot has not arrived");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result loaded over a word not yet taken");
`endif

endmodule

// ===== rtl/tick_process_scheduler.sv =====
// Top level of the tick process scheduler: controller plus datapath.
// Depends on tps_pkg, tps_ctrl and tps_dp.
//
//  channel | ports        | tdata / tuser                      | words
//  --------+--------------+------------------------------------+--------------------
//  in_     | tvalid/tready| tdata: burst_time; tuser: mode     | arrival or tick
//  out_    | tvalid/tready| tdata: run/fin valid, slots, done  | one per tick
//  cfg_    | valid/ready  | index: register, data: value       | policy/quantum/total
//
// An arrival is stored in the idle state. A tick that runs a job steps through read,
// retire, decide, apply, decrement, output; round robin pops after decide, and a
// shortest-job search reads remaining times on its single read port, one a cycle.
// Reset needs no clearing pass; the block takes words from the first cycle after it.
// A finished result waits in the output register while the next word is taken;
// a tick waits in its last cycle only while that register is still full.
module tick_process_scheduler #(
  parameter int MAX_JOBS  = tps_pkg::MaxJobsDef,
  parameter int TIME_BITS = tps_pkg::TimeBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tps_pkg::BURST_W-1:0]      in_tdata,   // [23:0] burst_time
  input  logic                             in_tuser,   // [0] mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] running_valid, [6:1] running_slot, [7] finished_valid,
  // [13:8] finished_slot, [14] all_done, [15] zero
  output logic [tps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tps_pkg::*;

  tps_cmd_t    cmd;
  tps_status_t status;

  assign cfg_ready = 1'b1;

  tps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  tps_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_burst   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
